// File: design/rcv_pkg.sv
// ----------------------------------------------------------------------------
// rcv_pkg: shared types and constants of the RGBA 5x5 convolution
// Word layouts of both channels, window and kernel types, pipeline control
// structs and the configuration register map.
// ----------------------------------------------------------------------------
`default_nettype none

package rcv_pkg;

  localparam int NUM_ROWS  = 5;   // kernel rows, one per input pixel
  localparam int NUM_TAPS  = 5;   // kernel columns
  localparam int HIST      = 4;   // previous columns kept in the window
  localparam int NUM_CH    = 4;   // R, G, B, A
  localparam int PIX_W     = 8;
  localparam int COEF_W    = 12;
  localparam int FRAC_W    = 8;   // Q4.8 coefficients
  localparam int PROD_W    = 20;  // 9-bit signed pixel times 12-bit signed coefficient
  localparam int ROWSUM_W  = 23;  // sum of five products
  localparam int SUM_W     = 25;  // sum of five row sums
  localparam int KREG_W    = 60;
  localparam int NUM_KREGS = 5;
  localparam int CFG_IDX_W = 3;

  localparam logic [KREG_W-1:0] KERNEL_RESET = 60'h00A00A00A00A00A;
  localparam logic [PIX_W-1:0]  PIX_MAX      = 8'hFF;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_KERNEL_ROW_0 = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_KERNEL_ROW_1 = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_KERNEL_ROW_2 = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_KERNEL_ROW_3 = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_KERNEL_ROW_4 = 3'd4;

  typedef logic [PIX_W*NUM_CH-1:0] pixel_t;

  typedef struct packed {
    pixel_t top2_pixel;
    pixel_t top1_pixel;
    pixel_t center_pixel;
    pixel_t bottom1_pixel;
    pixel_t bottom2_pixel;
    logic   first_in_row;
    logic   last_in_row;
  } in_word_t;

  typedef struct packed {
    pixel_t filtered_pixel;
    logic   row_end;
  } out_word_t;

  // Column index 0 is the oldest column; row index 0 is top2.
  typedef pixel_t [NUM_ROWS-1:0] column_t;
  typedef column_t [NUM_TAPS-1:0] view_t;
  typedef logic [NUM_TAPS-1:0][NUM_ROWS-1:0][PIX_W-1:0] chan_view_t;

  typedef logic [NUM_KREGS-1:0][KREG_W-1:0] kernel_t;

  typedef logic signed [SUM_W-1:0] sum_t;

  typedef struct packed {
    logic valid;
    logic row_end;
  } job_t;

  typedef struct packed {
    logic a;
    logic b;
    logic c;
  } pipe_en_t;

endpackage

`default_nettype wire

// File: design/rcv_window.sv
// ----------------------------------------------------------------------------
// rcv_window: sliding column window and row sequencer
// Keeps the four previous columns, handles left-edge fill and right-edge
// flush, and issues one five-column view per cycle to the lanes while take is high.
// ----------------------------------------------------------------------------
`default_nettype none

module rcv_window
  import rcv_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     in_valid,
  input  wire in_word_t in_data,
  output logic          in_ready,
  input  wire logic     take,
  output job_t          job,
  output view_t         view
);

  localparam logic [1:0] SEEN_NONE = 2'd0;
  localparam logic [1:0] SEEN_ONE  = 2'd1;
  localparam logic [1:0] SEEN_FULL = 2'd3;

  localparam logic [1:0] FLUSH_NONE = 2'd0;
  localparam logic [1:0] FLUSH_ONE  = 2'd1;
  localparam logic [1:0] FLUSH_TWO  = 2'd2;

  column_t [HIST-1:0] win_r, win_nxt;
  logic [1:0]         seen_r, seen_nxt;
  logic [1:0]         flush_r, flush_nxt;

  column_t    cur;
  logic       flushing;
  logic       fill;
  logic [1:0] seen_upd;
  logic       emit_norm;
  logic [1:0] pending;
  logic       item_acc;

  always_comb begin
    cur[0] = in_data.top2_pixel;
    cur[1] = in_data.top1_pixel;
    cur[2] = in_data.center_pixel;
    cur[3] = in_data.bottom1_pixel;
    cur[4] = in_data.bottom2_pixel;

    flushing = flush_r != FLUSH_NONE;
    // A new row starts on first_in_row or whenever no row is open.
    fill      = in_data.first_in_row || (seen_r == SEEN_NONE);
    seen_upd  = fill ? SEEN_ONE : ((seen_r == SEEN_FULL) ? SEEN_FULL : seen_r + 2'd1);
    emit_norm = seen_upd == SEEN_FULL;
    pending   = (seen_upd == SEEN_ONE) ? FLUSH_ONE : FLUSH_TWO;

    // During a flush the newest column stands in for the missing right columns.
    for (int t = 0; t < HIST; t++) begin
      view[t] = win_r[t];
    end
    view[HIST] = flushing ? win_r[HIST-1] : cur;

    in_ready    = take && !flushing;
    item_acc    = in_valid && in_ready;
    job.valid   = flushing || (in_valid && emit_norm);
    job.row_end = flushing && (flush_r == FLUSH_ONE);

    win_nxt   = win_r;
    seen_nxt  = seen_r;
    flush_nxt = flush_r;
    if (flushing && take) begin
      win_nxt   = {win_r[HIST-1], win_r[HIST-1:1]};
      flush_nxt = flush_r - 2'd1;
    end else if (item_acc) begin
      win_nxt   = fill ? {HIST{cur}} : {cur, win_r[HIST-1:1]};
      seen_nxt  = in_data.last_in_row ? SEEN_NONE : seen_upd;
      flush_nxt = in_data.last_in_row ? pending : FLUSH_NONE;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seen_r  <= SEEN_NONE;
      flush_r <= FLUSH_NONE;
    end else begin
      seen_r  <= seen_nxt;
      flush_r <= flush_nxt;
    end
  end

  always_ff @(posedge clk) begin
    win_r <= win_nxt;
  end

endmodule

`default_nettype wire

// File: design/rcv_lane.sv
// ----------------------------------------------------------------------------
// rcv_lane: 25-tap multiply-accumulate for one color channel
// Products, row sums and the total are each registered, three stages.
// ----------------------------------------------------------------------------
`default_nettype none

module rcv_lane
  import rcv_pkg::*;
(
  input  wire logic       clk,
  input  wire chan_view_t pix,
  input  wire kernel_t    kernel,
  input  wire pipe_en_t   en,
  output sum_t            sum
);

  typedef logic signed [PROD_W-1:0]   prod_t;
  typedef logic signed [ROWSUM_W-1:0] rowsum_t;

  function automatic logic signed [COEF_W-1:0] coef_at(kernel_t k, int r, int t);
    return k[r][COEF_W*t +: COEF_W];
  endfunction

  prod_t   prod_r   [NUM_ROWS][NUM_TAPS];
  prod_t   prod_nxt [NUM_ROWS][NUM_TAPS];
  rowsum_t rsum_r   [NUM_ROWS];
  rowsum_t rsum_nxt [NUM_ROWS];
  sum_t    sum_r, sum_nxt;

  always_comb begin
    for (int r = 0; r < NUM_ROWS; r++) begin
      for (int t = 0; t < NUM_TAPS; t++) begin
        prod_nxt[r][t] = $signed({1'b0, pix[t][r]}) * coef_at(kernel, r, t);
      end
    end

    for (int r = 0; r < NUM_ROWS; r++) begin
      rsum_nxt[r] = '0;
      for (int t = 0; t < NUM_TAPS; t++) begin
        rsum_nxt[r] = rsum_nxt[r] + rowsum_t'(prod_r[r][t]);
      end
    end

    sum_nxt = '0;
    for (int r = 0; r < NUM_ROWS; r++) begin
      sum_nxt = sum_nxt + sum_t'(rsum_r[r]);
    end
  end

  always_ff @(posedge clk) begin
    if (en.a) begin
      prod_r <= prod_nxt;
    end
    if (en.b) begin
      rsum_r <= rsum_nxt;
    end
    if (en.c) begin
      sum_r <= sum_nxt;
    end
  end

  assign sum = sum_r;

endmodule

`default_nettype wire

// File: design/rcv_merge.sv
// ----------------------------------------------------------------------------
// rcv_merge: channel clamp, packing and output register
// Floors each lane sum by the fraction bits, clamps to 0..255, packs RGBA.
// ----------------------------------------------------------------------------
`default_nettype none

module rcv_merge
  import rcv_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire sum_t sums [NUM_CH],
  input  wire job_t ctl,
  output logic      rdy,
  output logic      out_valid,
  input  wire logic out_ready,
  output out_word_t out_data
);

  function automatic logic [PIX_W-1:0] clamp_px(sum_t s);
    logic [SUM_W-FRAC_W-1:0] whole;
    whole = s[SUM_W-1:FRAC_W];
    if (s < 0) begin
      return '0;
    end else if (whole > (SUM_W-FRAC_W)'(PIX_MAX)) begin
      return PIX_MAX;
    end else begin
      return whole[PIX_W-1:0];
    end
  endfunction

  logic      out_valid_r, out_valid_nxt;
  out_word_t out_r, out_nxt;

  always_comb begin
    rdy = !out_valid_r || out_ready;
    out_valid_nxt = rdy ? ctl.valid : out_valid_r;
    for (int ch = 0; ch < NUM_CH; ch++) begin
      out_nxt.filtered_pixel[PIX_W*ch +: PIX_W] = clamp_px(sums[ch]);
    end
    out_nxt.row_end = ctl.row_end;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy) begin
      out_r <= out_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule

`default_nettype wire

// File: design/rgba_convolve_5x5.sv
// ----------------------------------------------------------------------------
// rgba_convolve_5x5: 5x5 RGBA8 convolution with clamp-to-edge borders
// Column-fed convolution: window, four channel lanes, clamp and output stage.
// ----------------------------------------------------------------------------
// The block takes one column of five pixels per clock and gives one filtered
// pixel per clock once a row has three columns, while no flush holds off the
// input and the output is not stalled. Each result's view enters the lanes on
// the edge that accepts the column that completes it, or on a flush cycle, and
// passes the product, row-sum and total registers and the output register
// before it is offered. On the last column of a row the window sequencer
// replays that column to flush the two pending outputs (one for a one-column
// row), and in_ready stays low during the flush. The four channel lanes each
// hold a registered three-stage tree of 25 multipliers; a stall at the output
// backs up only through full stages.
// Kernel rows may be written only while no word is in flight.
`default_nettype none

module rgba_convolve_5x5
  import rcv_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  in_valid,
  output logic                       in_ready,
  input  wire in_word_t              in_data,
  output logic                       out_valid,
  input  wire logic                  out_ready,
  output out_word_t                  out_data,
  input  wire logic                  cfg_we,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [KREG_W-1:0]     cfg_wdata
);

  kernel_t kernel_r, kernel_nxt;

  always_comb begin
    kernel_nxt = kernel_r;
    if (cfg_we) begin
      unique case (cfg_index)
        REG_KERNEL_ROW_0: kernel_nxt[0] = cfg_wdata;
        REG_KERNEL_ROW_1: kernel_nxt[1] = cfg_wdata;
        REG_KERNEL_ROW_2: kernel_nxt[2] = cfg_wdata;
        REG_KERNEL_ROW_3: kernel_nxt[3] = cfg_wdata;
        REG_KERNEL_ROW_4: kernel_nxt[4] = cfg_wdata;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      kernel_r <= {NUM_KREGS{KERNEL_RESET}};
    end else begin
      kernel_r <= kernel_nxt;
    end
  end

  // Pipeline control: a stage loads when it is empty or its successor moves.
  job_t     job;
  job_t     a_ctl_r, b_ctl_r, c_ctl_r;
  logic     rdy_a, rdy_b, rdy_c, rdy_out;
  pipe_en_t en;

  always_comb begin
    rdy_c = !c_ctl_r.valid || rdy_out;
    rdy_b = !b_ctl_r.valid || rdy_c;
    rdy_a = !a_ctl_r.valid || rdy_b;
    en.a  = rdy_a;
    en.b  = rdy_b;
    en.c  = rdy_c;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_ctl_r <= '0;
      b_ctl_r <= '0;
      c_ctl_r <= '0;
    end else begin
      if (rdy_a) begin
        a_ctl_r <= job;
      end
      if (rdy_b) begin
        b_ctl_r <= a_ctl_r;
      end
      if (rdy_c) begin
        c_ctl_r <= b_ctl_r;
      end
    end
  end

  view_t view;

  rcv_window u_window (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_data  (in_data),
    .in_ready (in_ready),
    .take     (rdy_a),
    .job      (job),
    .view     (view)
  );

  chan_view_t chan_view [NUM_CH];
  sum_t       sums      [NUM_CH];

  always_comb begin
    for (int ch = 0; ch < NUM_CH; ch++) begin
      for (int t = 0; t < NUM_TAPS; t++) begin
        for (int r = 0; r < NUM_ROWS; r++) begin
          chan_view[ch][t][r] = view[t][r][PIX_W*ch +: PIX_W];
        end
      end
    end
  end

  for (genvar ch = 0; ch < NUM_CH; ch++) begin : g_lane
    rcv_lane u_lane (
      .clk    (clk),
      .pix    (chan_view[ch]),
      .kernel (kernel_r),
      .en     (en),
      .sum    (sums[ch])
    );
  end

  rcv_merge u_merge (
    .clk       (clk),
    .rst_n     (rst_n),
    .sums      (sums),
    .ctl       (c_ctl_r),
    .rdy       (rdy_out),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

`default_nettype wire

// File: design/rcv_checker.sv
// ----------------------------------------------------------------------------
// rcv_checker: port-level checks of the RGBA 5x5 convolution
// Watches the top-level ports over time; bound to the top level below.
// ----------------------------------------------------------------------------
`default_nettype none

module rcv_checker
  import rcv_pkg::*;
(
  input wire logic                 clk,
  input wire logic                 rst_n,
  input wire logic                 in_valid,
  input wire logic                 in_ready,
  input wire in_word_t             in_data,
  input wire logic                 out_valid,
  input wire logic                 out_ready,
  input wire out_word_t            out_data,
  input wire logic                 cfg_we,
  input wire logic [CFG_IDX_W-1:0] cfg_index,
  input wire logic [KREG_W-1:0]    cfg_wdata
);

  // A stalled result word stays offered.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("out_valid dropped while stalled");

  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> $stable(out_data))
    else $error("out_data changed while stalled");

  // The last column of a row always starts a flush, which holds off input.
  a_flush_blocks: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && in_data.last_in_row |=> !in_ready)
    else $error("input accepted right after a row end");

  // Reset empties the pipeline, so no word is offered right after it.
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("out_valid high after reset");

endmodule

bind rgba_convolve_5x5 rcv_checker u_rcv_checker (.*);

`default_nettype wire

// File: tb/sv/tb_rgba_convolve_5x5.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_rgba_convolve_5x5: self-checking testbench of the 5x5 RGBA convolution
// Column words go in through a queue-fed driver and filtered pixels are
// checked by a monitor against a predictor of the sliding window and the
// kernel. Directed rows cover the edge cases and extreme kernels. Random rows
// follow, back to back first, then with random kernels and random gaps on both channels.
// ----------------------------------------------------------------------------
module tb_rgba_convolve_5x5
  import rcv_pkg::*;
();

  typedef logic [NUM_TAPS-1:0][NUM_ROWS-1:0][PIX_W*NUM_CH-1:0] tap_view_t;
  typedef logic [HIST-1:0][NUM_ROWS-1:0][PIX_W*NUM_CH-1:0] history_t;
  typedef logic [NUM_ROWS-1:0][PIX_W*NUM_CH-1:0] column_px_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  in_word_t in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  out_word_t out_data;
  logic cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = REG_KERNEL_ROW_0;
  logic [KREG_W-1:0] cfg_wdata = '0;

  always #6 clk = ~clk;

  rgba_convolve_5x5 dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_data(in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data(out_data),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata)
  );

  // Predictor state: kernel copy, four previous columns and the column count.
  logic [KREG_W-1:0] kern_model [NUM_KREGS];
  history_t win_model;
  int unsigned cols_in_row = 0;

  in_word_t column_queue[$];
  out_word_t expected_pixels[$];
  int words_sent = 0;
  int words_taken = 0;
  int mismatches = 0;
  bit idle_en = 1'b1;

  initial begin
    for (int i = 0; i < NUM_KREGS; i++) kern_model[i] = KERNEL_RESET;
    win_model = '0;
  end

  function automatic pixel_t convolve_view(input tap_view_t v);
    pixel_t res;
    int acc, px, cf, val;
    res = '0;
    for (int ch = 0; ch < NUM_CH; ch++) begin
      acc = 0;
      for (int r = 0; r < NUM_ROWS; r++) begin
        for (int t = 0; t < NUM_TAPS; t++) begin
          px = int'(v[t][r][PIX_W*ch +: PIX_W]);
          cf = int'($signed(kern_model[r][COEF_W*t +: COEF_W]));
          acc += px * cf;
        end
      end
      if (acc < 0) begin
        val = 0;
      end else begin
        val = acc >>> FRAC_W;
        if (val > 255) val = 255;
      end
      res[PIX_W*ch +: PIX_W] = val[PIX_W-1:0];
    end
    return res;
  endfunction

  task automatic push_pixel(input column_px_t cur, input logic row_end);
    out_word_t e;
    e.filtered_pixel = convolve_view({cur, win_model});
    e.row_end = row_end;
    expected_pixels.push_back(e);
  endtask

  task automatic predict_column(input in_word_t w);
    column_px_t cur;
    int pending;
    cur = {w.bottom2_pixel, w.bottom1_pixel, w.center_pixel, w.top1_pixel, w.top2_pixel};
    if (w.first_in_row || cols_in_row == 0) begin
      for (int t = 0; t < HIST; t++) win_model[t] = cur;
      cols_in_row = 1;
    end else if (cols_in_row < 3) begin
      cols_in_row++;
    end
    if (cols_in_row >= 3) push_pixel(cur, 1'b0);
    win_model = {cur, win_model[HIST-1:1]};
    if (w.last_in_row) begin
      // The last column is replayed to flush the outputs still pending.
      pending = (cols_in_row == 1) ? 1 : 2;
      for (int k = 0; k < pending; k++) begin
        push_pixel(cur, k == pending - 1);
        win_model = {cur, win_model[HIST-1:1]};
      end
      cols_in_row = 0;
    end
  endtask

  function automatic int idle_len();
    if ($urandom_range(0, 99) < 85) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // Driver: one word per handshake, random gaps between words.
  int in_gap = 0;
  always @(posedge clk) begin
    logic fire;
    fire = in_valid && in_ready;
    if (fire) begin
      predict_column(in_data);
      words_taken++;
    end
    if (!rst_n) begin
      in_valid <= 1'b0;
      in_gap <= 0;
    end else if (fire || !in_valid) begin
      if (in_gap != 0) begin
        in_valid <= 1'b0;
        in_gap <= in_gap - 1;
      end else if (column_queue.size() != 0) begin
        in_data <= column_queue.pop_front();
        in_valid <= 1'b1;
        in_gap <= (idle_en && $urandom_range(0, 99) < 35) ? idle_len() : 0;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Monitor: checks each accepted pixel and stalls the output at random.
  int out_gap = 0;
  always @(posedge clk) begin
    out_word_t want;
    if (out_valid && out_ready) begin
      if (expected_pixels.size() == 0) begin
        $display("%0t: unexpected word: expected none actual %h/%b", $time,
                 out_data.filtered_pixel, out_data.row_end);
        mismatches++;
      end else begin
        want = expected_pixels.pop_front();
        if (out_data.filtered_pixel !== want.filtered_pixel) begin
          $display("%0t: filtered_pixel mismatch: expected %h actual %h", $time,
                   want.filtered_pixel, out_data.filtered_pixel);
          mismatches++;
        end
        if (out_data.row_end !== want.row_end) begin
          $display("%0t: row_end mismatch: expected %b actual %b", $time,
                   want.row_end, out_data.row_end);
          mismatches++;
        end
      end
    end
    if (!rst_n) begin
      out_ready <= 1'b0;
      out_gap <= 0;
    end else if (out_gap != 0) begin
      out_ready <= 1'b0;
      out_gap <= out_gap - 1;
    end else if (idle_en && $urandom_range(0, 99) < 25) begin
      out_ready <= 1'b0;
      out_gap <= idle_len() - 1;
    end else begin
      out_ready <= 1'b1;
    end
  end

  function automatic pixel_t rand_pixel();
    case ($urandom_range(0, 9))
      0: return '0;
      1: return '1;
      default: return pixel_t'($urandom);
    endcase
  endfunction

  task automatic queue_column(input logic first_flag, input logic last_flag);
    in_word_t w;
    w.top2_pixel = rand_pixel();
    w.top1_pixel = rand_pixel();
    w.center_pixel = rand_pixel();
    w.bottom1_pixel = rand_pixel();
    w.bottom2_pixel = rand_pixel();
    w.first_in_row = first_flag;
    w.last_in_row = last_flag;
    column_queue.push_back(w);
    words_sent++;
  endtask

  task automatic queue_flat_column(input pixel_t px, input logic first_flag,
                                   input logic last_flag);
    in_word_t w;
    w = '{px, px, px, px, px, first_flag, last_flag};
    column_queue.push_back(w);
    words_sent++;
  endtask

  // Mostly well-formed rows; some start without the first flag, some are
  // abandoned without a last column, and a few carry random flags.
  task automatic queue_random_rows(input int target);
    int made, len, kind;
    logic first_flag, last_flag;
    made = 0;
    while (made < target) begin
      kind = $urandom_range(0, 99);
      len = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 16) : $urandom_range(1, 6);
      for (int c = 0; c < len; c++) begin
        if (kind >= 18 && kind < 24) begin
          first_flag = $urandom_range(0, 1);
          last_flag = ($urandom_range(0, 3) == 0);
        end else begin
          first_flag = (c == 0) && (kind >= 10);
          last_flag = (c == len - 1) && !(kind >= 10 && kind < 18);
        end
        queue_column(first_flag, last_flag);
      end
      made += len;
    end
  endtask

  task automatic write_kernel(input logic [CFG_IDX_W-1:0] idx,
                              input logic [KREG_W-1:0] value);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= value;
    kern_model[idx] = value;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic load_kernel(input logic [KREG_W-1:0] k0, k1, k2, k3, k4);
    write_kernel(REG_KERNEL_ROW_0, k0);
    write_kernel(REG_KERNEL_ROW_1, k1);
    write_kernel(REG_KERNEL_ROW_2, k2);
    write_kernel(REG_KERNEL_ROW_3, k3);
    write_kernel(REG_KERNEL_ROW_4, k4);
  endtask

  function automatic logic [KREG_W-1:0] rand_small_row();
    logic [KREG_W-1:0] row;
    int cf;
    for (int t = 0; t < NUM_TAPS; t++) begin
      cf = $urandom_range(0, 40) - 12;
      row[COEF_W*t +: COEF_W] = cf[COEF_W-1:0];
    end
    return row;
  endfunction

  function automatic logic [KREG_W-1:0] rand_full_row();
    logic [63:0] r;
    r = {$urandom, $urandom};
    return r[KREG_W-1:0];
  endfunction

  // Holds the sender until every expected pixel is out and the pipe is quiet.
  task automatic wait_drained();
    while (words_taken != words_sent || expected_pixels.size() != 0) @(posedge clk);
    repeat (12) @(posedge clk);
  endtask

  localparam logic [KREG_W-1:0] K_ZERO = '0;
  localparam logic [KREG_W-1:0] K_MINUS_ONE = '1;
  localparam logic [KREG_W-1:0] K_CENTER = {12'h000, 12'h000, 12'h100, 12'h000, 12'h000};
  localparam logic [KREG_W-1:0] K_MAX = {5{12'h7FF}};
  localparam logic [KREG_W-1:0] K_MIN = {5{12'h800}};

  initial begin
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    // Box filter from reset: one-column row, two-column row, a row opened
    // without the first flag, and a row abandoned by a new first column.
    queue_flat_column('1, 1'b1, 1'b1);
    queue_flat_column('0, 1'b1, 1'b0);
    queue_flat_column('1, 1'b0, 1'b1);
    queue_column(1'b0, 1'b0);
    queue_column(1'b0, 1'b0);
    queue_column(1'b0, 1'b1);
    queue_column(1'b1, 1'b0);
    queue_column(1'b0, 1'b0);
    queue_column(1'b1, 1'b0);
    queue_column(1'b0, 1'b0);
    queue_column(1'b0, 1'b1);
    wait_drained();

    // Center tap only: each output is the center pixel of its column.
    load_kernel(K_ZERO, K_ZERO, K_CENTER, K_ZERO, K_ZERO);
    queue_column(1'b1, 1'b0);
    for (int i = 0; i < 3; i++) queue_column(1'b0, 1'b0);
    queue_column(1'b0, 1'b1);
    wait_drained();

    // Largest positive taps saturate high.
    load_kernel(K_MAX, K_MAX, K_MAX, K_MAX, K_MAX);
    queue_column(1'b1, 1'b0);
    queue_column(1'b0, 1'b1);
    wait_drained();

    // Most negative taps clamp to zero.
    load_kernel(K_MIN, K_MIN, K_MIN, K_MIN, K_MIN);
    queue_flat_column('1, 1'b1, 1'b0);
    queue_column(1'b0, 1'b0);
    queue_column(1'b0, 1'b1);
    wait_drained();

    load_kernel(K_MINUS_ONE, K_ZERO, K_MINUS_ONE, K_ZERO, K_MINUS_ONE);
    queue_flat_column('1, 1'b1, 1'b1);
    wait_drained();

    // Random rows: back to back under the box filter first.
    idle_en = 1'b0;
    load_kernel(KERNEL_RESET, KERNEL_RESET, KERNEL_RESET, KERNEL_RESET, KERNEL_RESET);
    queue_random_rows(34);
    wait_drained();
    idle_en = 1'b1;

    load_kernel(rand_small_row(), rand_small_row(), rand_small_row(),
                rand_small_row(), rand_small_row());
    queue_random_rows(34);
    wait_drained();

    load_kernel(rand_full_row(), rand_full_row(), rand_full_row(),
                rand_full_row(), rand_full_row());
    queue_random_rows(34);
    wait_drained();

    load_kernel(rand_small_row(), rand_small_row(), rand_small_row(),
                rand_small_row(), rand_small_row());
    queue_random_rows(34);
    wait_drained();

    if (mismatches == 0) begin
      $display("tb_rgba_convolve_5x5: PASS");
    end else begin
      $display("tb_rgba_convolve_5x5: FAIL");
    end
    $finish;
  end

  initial begin
    #3000000;
    $display("tb_rgba_convolve_5x5: FAIL");
    $finish;
  end

endmodule

// File: rgba_convolve_5x5.f
design/rcv_pkg.sv
design/rcv_window.sv
design/rcv_lane.sv
design/rcv_merge.sv
design/rgba_convolve_5x5.sv
design/rcv_checker.sv
tb/sv/tb_rgba_convolve_5x5.sv
